// ===== src/scara_inverse_kinematics_assert.svh =====
// Assertion shorthands used by the checker file.
`ifndef SCARA_INVERSE_KINEMATICS_ASSERT_SVH
`define SCARA_INVERSE_KINEMATICS_ASSERT_SVH

// Clocked check, masked while reset is low.
`define SCIK_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define SCIK_CHECK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/scik_pkg.sv =====
package scik_pkg;

	localparam int COORD_WIDTH_DEF  = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int FIELD_W   = 16;
	localparam int LINK_W    = 15;
	localparam int CFG_IDX_W = 8;
	localparam int POS_W     = 17;
	localparam int CIN_W     = 35;
	localparam int MAG_W     = 41;
	localparam int CW        = 45;
	localparam int ACC_W     = 26;
	localparam int RAD_W     = 62;
	localparam int ROOT_W    = 31;
	localparam int SHOULDER_W = 17;
	localparam int ELBOW_W    = 15;

	localparam logic [LINK_W-1:0] LINK_RESET = 15'd4096;

	localparam logic signed [ACC_W-1:0] ANG_90 = 26'sd5898240;

	localparam int ELBOW_MAX    = 23040;
	localparam int SHOULDER_MIN = -46080;
	localparam int SHOULDER_MAX = 23040;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINK1 = 8'd0,
		REG_LINK2 = 8'd1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [POS_W-1:0] xs;
		logic signed [POS_W-1:0] ys;
		logic signed [CIN_W-1:0] numc;
		logic signed [CIN_W-1:0] k2;
		logic                    oor;
	} side_t;

	// atan(2^-i) in 1/65536 degree
	function automatic logic signed [ACC_W-1:0] atan_tab(input int i);
		case (i)
			0:  return ACC_W'(2949120);
			1:  return ACC_W'(1740967);
			2:  return ACC_W'(919879);
			3:  return ACC_W'(466945);
			4:  return ACC_W'(234379);
			5:  return ACC_W'(117304);
			6:  return ACC_W'(58666);
			7:  return ACC_W'(29335);
			8:  return ACC_W'(14668);
			9:  return ACC_W'(7334);
			10: return ACC_W'(3667);
			11: return ACC_W'(1833);
			12: return ACC_W'(917);
			13: return ACC_W'(458);
			14: return ACC_W'(229);
			15: return ACC_W'(115);
			16: return ACC_W'(57);
			17: return ACC_W'(29);
			18: return ACC_W'(14);
			19: return ACC_W'(7);
			20: return ACC_W'(4);
			21: return ACC_W'(2);
			22: return ACC_W'(1);
			default: return '0;
		endcase
	endfunction

endpackage

// ===== src/scik_cordic.sv =====
module scik_cordic #(
	parameter int STEPS = scik_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [scik_pkg::CIN_W-1:0]   x_in,
	input  logic signed [scik_pkg::CIN_W-1:0]   y_in,
	output logic signed [scik_pkg::ACC_W-1:0]   angle
);
	import scik_pkg::*;

	localparam int NSH = 6;

	logic             sx_s [0:NSH];
	logic             sy_s [0:NSH];
	logic [MAG_W-1:0] mx_s [0:NSH];
	logic [MAG_W-1:0] my_s [0:NSH];
	logic             zr_s [0:NSH];

	logic signed [CW-1:0]    cx_s [0:STEPS];
	logic signed [CW-1:0]    cy_s [0:STEPS];
	logic signed [ACC_W-1:0] ca_s [0:STEPS];
	logic                    cz_s [0:STEPS];

	logic signed [CIN_W-1:0] ax_c, ay_c;
	assign ax_c = x_in[CIN_W-1] ? -x_in : x_in;
	assign ay_c = y_in[CIN_W-1] ? -y_in : y_in;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s[0] <= x_in[CIN_W-1];
			sy_s[0] <= y_in[CIN_W-1];
			mx_s[0] <= MAG_W'(unsigned'(ax_c));
			my_s[0] <= MAG_W'(unsigned'(ay_c));
			zr_s[0] <= (x_in == '0) && (y_in == '0);
		end
	end

	// binary search for the left shift that brings the larger magnitude near 2^40
	for (genvar j = 0; j < NSH; j++) begin : g_norm
		localparam int SH = 1 << (NSH - 1 - j);
		logic fits_c;
		assign fits_c = ((mx_s[j] | my_s[j]) >> (MAG_W - 1 - SH)) == '0;
		always_ff @(posedge clk) begin
			if (en) begin
				sx_s[j+1] <= sx_s[j];
				sy_s[j+1] <= sy_s[j];
				zr_s[j+1] <= zr_s[j];
				mx_s[j+1] <= fits_c ? (mx_s[j] << SH) : mx_s[j];
				my_s[j+1] <= fits_c ? (my_s[j] << SH) : my_s[j];
			end
		end
	end

	logic             low_c;
	logic [MAG_W-1:0] nx_c, ny_c;
	logic signed [CW-1:0] px_c, py_c;
	assign low_c = ((mx_s[NSH] | my_s[NSH]) >> (MAG_W - 1)) == '0;
	assign nx_c  = low_c ? (mx_s[NSH] << 1) : mx_s[NSH];
	assign ny_c  = low_c ? (my_s[NSH] << 1) : my_s[NSH];
	assign px_c  = sx_s[NSH] ? -$signed(CW'(nx_c)) : $signed(CW'(nx_c));
	assign py_c  = sy_s[NSH] ? -$signed(CW'(ny_c)) : $signed(CW'(ny_c));

	// fold the left half plane over by a quarter turn
	always_ff @(posedge clk) begin
		if (en) begin
			cz_s[0] <= zr_s[NSH];
			if (px_c < 0 && py_c >= 0) begin
				cx_s[0] <= py_c;
				cy_s[0] <= -px_c;
				ca_s[0] <= ANG_90;
			end else if (px_c < 0) begin
				cx_s[0] <= -py_c;
				cy_s[0] <= px_c;
				ca_s[0] <= -ANG_90;
			end else begin
				cx_s[0] <= px_c;
				cy_s[0] <= py_c;
				ca_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [ACC_W-1:0] TAB = atan_tab(i);
		logic signed [CW-1:0] dx_c, dy_c;
		assign dx_c = cy_s[i] >>> i;
		assign dy_c = cx_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				cz_s[i+1] <= cz_s[i];
				if (cy_s[i] > 0) begin
					cx_s[i+1] <= cx_s[i] + dx_c;
					cy_s[i+1] <= cy_s[i] - dy_c;
					ca_s[i+1] <= ca_s[i] + TAB;
				end else begin
					cx_s[i+1] <= cx_s[i] - dx_c;
					cy_s[i+1] <= cy_s[i] + dy_c;
					ca_s[i+1] <= ca_s[i] - TAB;
				end
			end
		end
	end

	assign angle = cz_s[STEPS] ? '0 : ca_s[STEPS];

endmodule

// ===== src/scara_inverse_kinematics.sv =====
// Two-link planar arm inverse kinematics, elbow-down solution.
// Input stream s_*: one target (x, y) per transaction, 1/4096 m per unit.
// Output stream m_*: shoulder and elbow angles in 1/128 degree; tuser is the
// reach status (1: out of reach, angles zero). One result per target, in order.
// Config channel cfg_*: index 0 writes link 1, index 1 writes link 2, other
// indexes are dropped; cfg_ready is always high. Write only while idle.
// Throughput: one target per cycle while the output is not stalled. Stages, in order:
// 7 front stages for squares, reach test and clamp, 31 stages of the
// bit-per-stage square root, CORDIC_STEPS + 8 stages of the three parallel
// atan2 units (input, six normalize, quadrant fold, iterations), then
// difference and round/clamp stages.
// Reset: valid bits clear, both links return to 4096.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
module scara_inverse_kinematics #(
	parameter int COORD_WIDTH  = scik_pkg::COORD_WIDTH_DEF,
	parameter int CORDIC_STEPS = scik_pkg::CORDIC_STEPS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [31:0]                        s_tdata,   // [15:0] target_x, [31:16] target_y
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [31:0]                        m_tdata,   // [16:0] shoulder_angle, [31:17] elbow_angle
	output logic [0:0]                         m_tuser,   // [0] reach_status
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [scik_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [scik_pkg::LINK_W-1:0]        cfg_data
);
	import scik_pkg::*;

	localparam int CL = CORDIC_STEPS + 8;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign cfg_ready = 1'b1;

	// link registers
	logic [LINK_W-1:0] link1_q, link2_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link1_q <= LINK_RESET;
			link2_q <= LINK_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LINK1: link1_q <= cfg_data;
				REG_LINK2: link2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// terms that depend on the links only
	logic [2*LINK_W-1:0] a12_c, a1sq_q, a2sq_q;
	logic [LINK_W:0]     lsum_c;
	logic [LINK_W-1:0]   ldif_c;
	logic [2*LINK_W+1:0] sum2_q;
	logic [2*LINK_W-1:0] dif2_q;
	logic [2*LINK_W:0]   den_q, twoa1sq_q;
	logic [RAD_W-1:0]    den2_q;
	logic                link_zero_q;

	assign a12_c  = link1_q * link2_q;
	assign lsum_c = link1_q + link2_q;
	assign ldif_c = (link1_q > link2_q) ? (link1_q - link2_q) : (link2_q - link1_q);

	always_ff @(posedge clk) begin
		a1sq_q      <= link1_q * link1_q;
		a2sq_q      <= link2_q * link2_q;
		den_q       <= {a12_c, 1'b0};
		sum2_q      <= lsum_c * lsum_c;
		dif2_q      <= ldif_c * ldif_c;
		link_zero_q <= (link1_q == '0) || (link2_q == '0);
		twoa1sq_q   <= {a1sq_q, 1'b0};
		den2_q      <= den_q * den_q;
	end

	// input sign extension from COORD_WIDTH bits; zero extension of 16 bits when wider
	logic signed [POS_W-1:0] x_c, y_c;
	if (COORD_WIDTH <= FIELD_W) begin : g_sext
		assign x_c = POS_W'(signed'(s_tdata[COORD_WIDTH-1:0]));
		assign y_c = POS_W'(signed'(s_tdata[FIELD_W+COORD_WIDTH-1:FIELD_W]));
	end else begin : g_zext
		assign x_c = signed'({1'b0, s_tdata[FIELD_W-1:0]});
		assign y_c = signed'({1'b0, s_tdata[2*FIELD_W-1:FIELD_W]});
	end

	// front stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [POS_W-1:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3, x_s4, y_s4;
	logic signed [POS_W-1:0] x_s5, y_s5, x_s6, y_s6;
	logic [2*FIELD_W-1:0]    sqx_s2, sqy_s2;
	logic [2*FIELD_W:0]      r2_s3;
	logic                    oor_s3, oor_s4, oor_s5, oor_s6;
	logic signed [CIN_W-1:0] num_s4, numc_s5, numc_s6, k2_s6;
	logic [ROOT_W-1:0]       nmag_s5;
	logic [RAD_W-1:0]        num2_s6;

	logic [FIELD_W-1:0]      ux_c, uy_c;
	logic [2*FIELD_W:0]      r2_c;
	logic signed [CIN_W-1:0] den_c;

	assign ux_c  = FIELD_W'(x_s1[POS_W-1] ? -x_s1 : x_s1);
	assign uy_c  = FIELD_W'(y_s1[POS_W-1] ? -y_s1 : y_s1);
	assign r2_c  = sqx_s2 + sqy_s2;
	assign den_c = $signed(CIN_W'(den_q));

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x_c;
			y_s1 <= y_c;

			x_s2   <= x_s1;
			y_s2   <= y_s1;
			sqx_s2 <= ux_c * ux_c;
			sqy_s2 <= uy_c * uy_c;

			x_s3   <= x_s2;
			y_s3   <= y_s2;
			r2_s3  <= r2_c;
			oor_s3 <= link_zero_q || (r2_c > {1'b0, sum2_q}) || (r2_c < (2*FIELD_W+1)'(dif2_q));

			x_s4   <= x_s3;
			y_s4   <= y_s3;
			oor_s4 <= oor_s3;
			num_s4 <= $signed(CIN_W'(r2_s3)) - $signed(CIN_W'(a1sq_q))
				- $signed(CIN_W'(a2sq_q));

			x_s5   <= x_s4;
			y_s5   <= y_s4;
			oor_s5 <= oor_s4;
			if (num_s4 > den_c) begin
				numc_s5 <= den_c;
				nmag_s5 <= ROOT_W'(den_q);
			end else if (num_s4 < -den_c) begin
				numc_s5 <= -den_c;
				nmag_s5 <= ROOT_W'(den_q);
			end else begin
				numc_s5 <= num_s4;
				nmag_s5 <= ROOT_W'(num_s4[CIN_W-1] ? -num_s4 : num_s4);
			end

			x_s6    <= x_s5;
			y_s6    <= y_s5;
			oor_s6  <= oor_s5;
			numc_s6 <= numc_s5;
			num2_s6 <= nmag_s5 * nmag_s5;
			k2_s6   <= $signed(CIN_W'(twoa1sq_q)) + numc_s5;
		end
	end

	// square root, one result bit per stage
	logic [RAD_W-1:0] isn_s [0:ROOT_W];
	logic [RAD_W-1:0] isr_s [0:ROOT_W];
	side_t            isd_s [0:ROOT_W];
	logic             isv_s [0:ROOT_W];

	assign isv_s[0] = v_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			isn_s[0]      <= den2_q - num2_s6;
			isr_s[0]      <= '0;
			isd_s[0].xs   <= x_s6;
			isd_s[0].ys   <= y_s6;
			isd_s[0].numc <= numc_s6;
			isd_s[0].k2   <= k2_s6;
			isd_s[0].oor  <= oor_s6;
		end
	end

	for (genvar j = 0; j < ROOT_W; j++) begin : g_isq
		localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (ROOT_W - 1 - j));
		logic [RAD_W:0] trial_c;
		assign trial_c = {1'b0, isr_s[j]} + {1'b0, BIT};
		always_ff @(posedge clk) begin
			if (en) begin
				isd_s[j+1] <= isd_s[j];
				if ({1'b0, isn_s[j]} >= trial_c) begin
					isn_s[j+1] <= isn_s[j] - trial_c[RAD_W-1:0];
					isr_s[j+1] <= (isr_s[j] >> 1) + BIT;
				end else begin
					isn_s[j+1] <= isn_s[j];
					isr_s[j+1] <= isr_s[j] >> 1;
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				isv_s[j+1] <= 1'b0;
			end else if (en) begin
				isv_s[j+1] <= isv_s[j];
			end
		end
	end

	// three atan2 units side by side
	side_t                   sd_c;
	logic signed [CIN_W-1:0] s_c;
	logic signed [ACC_W-1:0] ang_elb_c, ang_tgt_c, ang_off_c;

	assign sd_c = isd_s[ROOT_W];
	assign s_c  = $signed(CIN_W'(isr_s[ROOT_W][ROOT_W-1:0]));

	scik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_elb (
		.clk   (clk),
		.en    (en),
		.x_in  (sd_c.numc),
		.y_in  (s_c),
		.angle (ang_elb_c)
	);

	scik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_tgt (
		.clk   (clk),
		.en    (en),
		.x_in  (CIN_W'(sd_c.xs)),
		.y_in  (CIN_W'(sd_c.ys)),
		.angle (ang_tgt_c)
	);

	scik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_off (
		.clk   (clk),
		.en    (en),
		.x_in  (sd_c.k2),
		.y_in  (s_c),
		.angle (ang_off_c)
	);

	logic cv_s  [0:CL];
	logic coor_s [0:CL];
	assign cv_s[0]   = isv_s[ROOT_W];
	assign coor_s[0] = sd_c.oor;

	for (genvar k = 0; k < CL; k++) begin : g_cdly
		always_ff @(posedge clk) begin
			if (en) begin
				coor_s[k+1] <= coor_s[k];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[k+1] <= 1'b0;
			end else if (en) begin
				cv_s[k+1] <= cv_s[k];
			end
		end
	end

	// angle difference, then round to 1/128 degree and clamp
	logic                    v_t;
	logic                    oor_t;
	logic signed [ACC_W:0]   t1_t;
	logic signed [ACC_W-1:0] t2_t;
	logic signed [ACC_W:0]   r1_c;
	logic signed [ACC_W-1:0] r2a_c;
	logic signed [ACC_W-9:0] q1_c;
	logic signed [ACC_W-10:0] q2_c;
	logic [SHOULDER_W-1:0]   sh_c;
	logic [ELBOW_W-1:0]      el_c;

	assign r1_c  = t1_t + (ACC_W+1)'(256);
	assign r2a_c = t2_t + ACC_W'(256);
	assign q1_c  = (ACC_W-8)'(r1_c >>> 9);
	assign q2_c  = (ACC_W-9)'(r2a_c >>> 9);

	always_comb begin
		if (q1_c < (ACC_W-8)'(SHOULDER_MIN)) begin
			sh_c = SHOULDER_W'(SHOULDER_MIN);
		end else if (q1_c > (ACC_W-8)'(SHOULDER_MAX)) begin
			sh_c = SHOULDER_W'(SHOULDER_MAX);
		end else begin
			sh_c = SHOULDER_W'(q1_c);
		end
		if (q2_c < 0) begin
			el_c = '0;
		end else if (q2_c > (ACC_W-9)'(ELBOW_MAX)) begin
			el_c = ELBOW_W'(ELBOW_MAX);
		end else begin
			el_c = ELBOW_W'(q2_c);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t1_t  <= (ACC_W+1)'(ang_tgt_c) - (ACC_W+1)'(ang_off_c);
			t2_t  <= ang_elb_c;
			oor_t <= coor_s[CL];
			m_tuser <= oor_t;
			m_tdata <= oor_t ? '0 : {el_c, sh_c};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			v_s7     <= 1'b0;
			v_t      <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_s1     <= s_tvalid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			v_s5     <= v_s4;
			v_s6     <= v_s5;
			v_s7     <= v_s6;
			v_t      <= cv_s[CL];
			m_tvalid <= v_t;
		end
	end

endmodule

// ===== src/scik_checker.sv =====
`include "scara_inverse_kinematics_assert.svh"

module scik_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [31:0]                    s_tdata,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [31:0]                    m_tdata,
	input logic [0:0]                     m_tuser,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [scik_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [scik_pkg::LINK_W-1:0]    cfg_data
);
	import scik_pkg::*;

	`SCIK_CHECK_ALWAYS(a_reset_empty, !arst_n |-> !m_tvalid, "output valid during reset")
	`SCIK_CHECK(a_hold_on_stall, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
	`SCIK_CHECK(a_ready_when_empty, !m_tvalid |-> s_tready, "input blocked with empty output")
	`SCIK_CHECK(a_unreachable_zero, m_tvalid && m_tuser[0] |-> m_tdata == '0, "unreachable result carries angles")
	`SCIK_CHECK(a_elbow_range, m_tvalid |-> m_tdata[31:17] <= ELBOW_W'(ELBOW_MAX), "elbow angle above half turn")

endmodule

bind scara_inverse_kinematics scik_checker u_scik_checker (.*);
